// ===== hdl/pmtp_pkg.sv =====
// Shared types and constants for the program map section parser.
// No dependencies; the result and config interfaces, the result queue and the parser core import it.
package pmtp_pkg;

	localparam int unsigned PID_W = 13;
	localparam int unsigned LEN_W = 12;
	localparam int unsigned CFG_IDX_W = 2;

	// Longest accepted section length and the shortest one that still holds
	// the fixed header fields and the CRC.
	localparam logic [LEN_W-1:0] MAX_SECTION_BYTES = 12'd1021;
	localparam logic [LEN_W-1:0] MIN_SECTION_BYTES = 12'd13;

	// Byte positions inside the section header
	localparam logic [LEN_W-1:0] POS_SEC_LEN_HI  = 12'd1;
	localparam logic [LEN_W-1:0] POS_SEC_LEN_LO  = 12'd2;
	localparam logic [LEN_W-1:0] POS_PROG_INFO_HI = 12'd10;
	localparam logic [LEN_W-1:0] POS_PROG_INFO_LO = 12'd11;
	localparam logic [LEN_W:0]   POS_PROG_DESC   = 13'd12;
	localparam logic [LEN_W-1:0] CRC_TAIL_BYTES  = 12'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_TYPE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUDIO1_TYPE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUDIO2_TYPE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TELETEXT_TYPE = 2'd3;

	// Header byte of an elementary stream entry
	localparam logic [2:0] ES_TYPE    = 3'd0;
	localparam logic [2:0] ES_PID_HI  = 3'd1;
	localparam logic [2:0] ES_PID_LO  = 3'd2;
	localparam logic [2:0] ES_INFO_HI = 3'd3;
	localparam logic [2:0] ES_INFO_LO = 3'd4;

	typedef struct packed {
		logic [PID_W-1:0] video_es_pid;
		logic             video_found;
		logic [PID_W-1:0] audio_pid_first;
		logic [PID_W-1:0] audio_pid_second;
		logic             teletext_found;
		logic             malformed;
	} pmtp_result_t;

endpackage

// ===== hdl/pmtp_section_if.sv =====
// Section byte channel: one beat per byte of a program map section.
// Depends on nothing.
interface pmtp_section_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       section_start;

	modport source (output valid, output data_byte, output section_start, input ready);
	modport sink (input valid, input data_byte, input section_start, output ready);
endinterface

// ===== hdl/pmtp_result_if.sv =====
// Result channel: one beat per finished (or rejected) section.
// Depends on pmtp_pkg for field widths.
interface pmtp_result_if import pmtp_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [PID_W-1:0] video_es_pid;
	logic             video_found;
	logic [PID_W-1:0] audio_pid_first;
	logic [PID_W-1:0] audio_pid_second;
	logic             teletext_found;
	logic             malformed;

	modport source (output valid, output video_es_pid, output video_found,
		output audio_pid_first, output audio_pid_second, output teletext_found,
		output malformed, input ready);
	modport sink (input valid, input video_es_pid, input video_found,
		input audio_pid_first, input audio_pid_second, input teletext_found,
		input malformed, output ready);
endinterface

// ===== hdl/pmtp_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
// Depends on pmtp_pkg for the index width.
interface pmtp_cfg_if import pmtp_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [7:0]           wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== hdl/pmtp_result_fifo.sv =====
// Two-entry result queue that decouples the parser from output back-pressure.
// Depends on pmtp_pkg and pmtp_result_if.
module pmtp_result_fifo import pmtp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  pmtp_result_t         push_data,
	output logic                 full,
	pmtp_result_if.source        result
);

	pmtp_result_t entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         pop;
	pmtp_result_t head;

	assign full = (count_q == 2'd2);
	assign pop  = result.valid && result.ready;
	assign head = entry_q[rd_ptr_q];

	assign result.valid            = (count_q != 2'd0);
	assign result.video_es_pid     = head.video_es_pid;
	assign result.video_found      = head.video_found;
	assign result.audio_pid_first  = head.audio_pid_first;
	assign result.audio_pid_second = head.audio_pid_second;
	assign result.teletext_found   = head.teletext_found;
	assign result.malformed        = head.malformed;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("result queue count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("result pushed into full queue");

	a_ptrs_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

// ===== hdl/pmt_section_parser_core.sv =====
// Program map section parser: takes one section byte per beat and returns,
// at the last CRC byte, the PIDs of the video and the two audio streams, the
// teletext flag and a malformed flag; a section with a bad length is reported
// at its third byte. The parse state advances in the cycle a byte is accepted
// and the result lands in a two-entry queue, so bytes flow at one per cycle and
// input stalls only when both queue entries wait on the result side.
// Configuration writes take effect the next cycle.
// Depends on pmtp_pkg, the three channel interfaces and pmtp_result_fifo.
module pmt_section_parser_core import pmtp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	pmtp_section_if.sink    section,
	pmtp_result_if.source   result,
	pmtp_cfg_if.sink        cfg
);

	// configuration
	logic [7:0] video_type_q, audio1_type_q, audio2_type_q, teletext_type_q;

	// parse state
	logic             in_section_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] size_q;
	logic [LEN_W-1:0] desc_q;
	logic [2:0]       efp_q;
	logic [7:0]       es_type_q;
	logic [PID_W-1:0] es_pid_q;
	logic [LEN_W-1:0] skip_q;
	pmtp_result_t     found_q;

	logic             in_section_d;
	logic [LEN_W-1:0] pos_d, size_d, desc_d, skip_d;
	logic [2:0]       efp_d;
	logic [7:0]       es_type_d;
	logic [PID_W-1:0] es_pid_d;
	pmtp_result_t     found_d;
	logic             emit;

	logic             accept;
	logic             fifo_full;
	logic [7:0]       b;
	logic [LEN_W-1:0] sz_full, di_full, di_limit, size_m1, size_end;
	logic [LEN_W:0]   area_start;

	assign accept    = section.valid && section.ready;
	assign section.ready = !fifo_full;
	assign cfg.ready = 1'b1;
	assign b         = section.data_byte;

	assign sz_full    = size_q | {4'd0, b};
	assign di_full    = desc_q | {4'd0, b};
	assign di_limit   = size_q - MIN_SECTION_BYTES;
	assign size_m1    = size_q - 12'd1;
	assign size_end   = size_q + CRC_TAIL_BYTES;
	assign area_start = POS_PROG_DESC + {1'b0, desc_q};

	always_comb begin
		in_section_d = in_section_q;
		pos_d        = pos_q;
		size_d       = size_q;
		desc_d       = desc_q;
		efp_d        = efp_q;
		es_type_d    = es_type_q;
		es_pid_d     = es_pid_q;
		skip_d       = skip_q;
		found_d      = found_q;
		emit         = 1'b0;

		if (accept && section.section_start) begin
			// abandon anything in progress, start fresh at byte 1
			in_section_d = 1'b1;
			pos_d        = 12'd1;
			size_d       = '0;
			desc_d       = '0;
			efp_d        = ES_TYPE;
			es_type_d    = '0;
			es_pid_d     = '0;
			skip_d       = '0;
			found_d      = '0;
		end else if (accept && in_section_q) begin
			pos_d = pos_q + 12'd1;
			if (pos_q == POS_SEC_LEN_HI) begin
				size_d = {b[3:0], 8'd0};
			end else if (pos_q == POS_SEC_LEN_LO) begin
				size_d = sz_full;
				if (sz_full > MAX_SECTION_BYTES || sz_full < MIN_SECTION_BYTES) begin
					found_d.malformed = 1'b1;
					in_section_d      = 1'b0;
					emit              = 1'b1;
				end
			end else if (pos_q < POS_PROG_INFO_HI) begin
				// fixed header bytes, nothing to keep
			end else if (pos_q == POS_PROG_INFO_HI) begin
				desc_d = {b[3:0], 8'd0};
			end else if (pos_q == POS_PROG_INFO_LO) begin
				desc_d = di_full;
				if (di_full > di_limit) begin
					desc_d            = di_limit;
					found_d.malformed = 1'b1;
				end
			end else if ({1'b0, pos_q} < area_start) begin
				// program descriptors: skip
			end else if (pos_q < size_m1) begin
				if (efp_q == ES_TYPE && skip_q != '0) begin
					skip_d = skip_q - 12'd1;
				end else begin
					case (efp_q)
						ES_TYPE: begin
							es_type_d = b;
							efp_d     = ES_PID_HI;
						end
						ES_PID_HI: begin
							es_pid_d = {b[4:0], 8'd0};
							efp_d    = ES_PID_LO;
						end
						ES_PID_LO: begin
							es_pid_d = es_pid_q | {5'd0, b};
							efp_d    = ES_INFO_HI;
						end
						ES_INFO_HI: begin
							skip_d = {b[3:0], 8'd0};
							efp_d  = ES_INFO_LO;
						end
						default: begin
							skip_d = skip_q | {4'd0, b};
							efp_d  = ES_TYPE;
							// first matching code wins
							if (es_type_q == video_type_q) begin
								found_d.video_es_pid = es_pid_q;
								found_d.video_found  = 1'b1;
							end else if (es_type_q == audio1_type_q) begin
								found_d.audio_pid_first = es_pid_q;
							end else if (es_type_q == audio2_type_q) begin
								found_d.audio_pid_second = es_pid_q;
							end else if (es_type_q == teletext_type_q) begin
								found_d.teletext_found = 1'b1;
							end
						end
					endcase
				end
			end else if (pos_q == size_m1) begin
				// entry area ends here: an unfinished entry is an overrun
				if (efp_q != ES_TYPE || skip_q != '0) begin
					found_d.malformed = 1'b1;
				end
				efp_d  = ES_TYPE;
				skip_d = '0;
			end else if (pos_q == size_end) begin
				in_section_d = 1'b0;
				emit         = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			video_type_q    <= 8'd2;
			audio1_type_q   <= 8'd3;
			audio2_type_q   <= 8'd4;
			teletext_type_q <= 8'd6;
			in_section_q    <= 1'b0;
			pos_q           <= '0;
			size_q          <= '0;
			desc_q          <= '0;
			efp_q           <= ES_TYPE;
			es_type_q       <= '0;
			es_pid_q        <= '0;
			skip_q          <= '0;
			found_q         <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					CFG_VIDEO_TYPE:    video_type_q    <= cfg.wdata;
					CFG_AUDIO1_TYPE:   audio1_type_q   <= cfg.wdata;
					CFG_AUDIO2_TYPE:   audio2_type_q   <= cfg.wdata;
					CFG_TELETEXT_TYPE: teletext_type_q <= cfg.wdata;
					default:           teletext_type_q <= teletext_type_q;
				endcase
			end
			in_section_q <= in_section_d;
			pos_q        <= pos_d;
			size_q       <= size_d;
			desc_q       <= desc_d;
			efp_q        <= efp_d;
			es_type_q    <= es_type_d;
			es_pid_q     <= es_pid_d;
			skip_q       <= skip_d;
			found_q      <= found_d;
		end
	end

	pmtp_result_fifo u_result_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (found_d),
		.full      (fifo_full),
		.result    (result)
	);

	a_emit_in_section: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (in_section_q && !section.section_start))
		else $error("result raised outside a section");

	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !in_section_q) else $error("section still open after its result");

	a_efp_range: assert property (@(posedge clk) disable iff (!arst_n)
		efp_q <= ES_INFO_LO) else $error("entry field position out of range");

	a_desc_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(in_section_q && pos_q > POS_PROG_INFO_LO) |->
		({1'b0, desc_q} + 13'd13 <= {1'b0, size_q}))
		else $error("program info length exceeds section");

endmodule
